>>> rtl/orc_pkg.sv
`timescale 1ns / 1ps
package orc_pkg;
    localparam int KEY_W = 32;
    localparam int SIZE_W = 20;
    localparam int USE_W = 32;
    localparam int CAP_W = 24;
    localparam int CNT_W = 32;
    localparam int EVC_W = 7;
    localparam logic [USE_W-1:0] NEVER_USE = {USE_W{1'b1}};

    // one table entry as stored in memory
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
        logic [USE_W-1:0]  next_use;
    } entry_t;
endpackage

>>> rtl/optimal_replacement_cache_unit.sv
`timescale 1ns / 1ps
// Belady optimal replacement for a cache of variable-size items. A request
// transaction is taken on start while busy is low. Exactly one result is shown
// for one cycle under done, in the cycle in which busy falls, and the receiver
// cannot hold it off. Every request scans the entry memory once for the key,
// then passes through a decide step and a done step. Each eviction adds a scan
// for the farthest next use, an evict step and another decide step, so busy
// stays high longer for every eviction. The entry memory has a single read
// port, so each scan walks it address by address. Valid bits are flip-flops.
module optimal_replacement_cache_unit #(
    parameter int ENTRIES = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [orc_pkg::CAP_W-1:0]      cfg_wdata,
    input  logic                           start,
    output logic                           busy,
    input  logic [orc_pkg::KEY_W-1:0]      item_key,
    input  logic [orc_pkg::SIZE_W-1:0]     item_size,
    input  logic [orc_pkg::USE_W-1:0]      next_use,
    output logic                           done,
    output logic                           hit,
    output logic                           admitted,
    output logic [orc_pkg::EVC_W-1:0]      evicted_count,
    output logic [orc_pkg::CAP_W-1:0]      occupied_size,
    output logic [orc_pkg::CNT_W-1:0]      request_total,
    output logic [orc_pkg::CNT_W-1:0]      miss_total
);
    import orc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PTR_W = $clog2(ENTRIES + 2);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(ENTRIES);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOOKUP = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_EVICT  = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [CAP_W-1:0]    capacity_reg;
    logic [ENTRIES-1:0]  valid_reg;
    logic [CAP_W-1:0]    occupied_reg;
    logic [CNT_W-1:0]    req_reg, miss_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [USE_W-1:0]    use_reg;
    logic [PTR_W-1:0]    ptr_reg;
    logic                found_reg, best_ok_reg, hit_reg, adm_reg;
    logic [IDX_W-1:0]    found_idx_reg, best_idx_reg;
    logic [USE_W-1:0]    best_use_reg;
    logic [SIZE_W-1:0]   best_size_reg;
    logic [EVC_W-1:0]    evc_reg;
    logic                done_reg;

    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr, rd_addr, rd_idx, free_idx;
    entry_t              wr_data, rd_data;
    logic                rd_live, free_ok, fits;
    logic [CAP_W:0]      need;

    orc_entry_mem #(.ENTRIES(ENTRIES), .IDX_W(IDX_W)) u_mem (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    // ptr walks addresses; rd_data holds the entry at ptr-1 from the registered read
    assign rd_addr = ptr_reg[IDX_W-1:0];
    assign rd_idx  = IDX_W'(ptr_reg - PTR_W'(1));
    assign rd_live = (ptr_reg != '0) && valid_reg[rd_idx];

    // lowest free slot from the valid bits
    always_comb
    begin
        free_ok = 1'b0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_ok = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign need = {1'b0, occupied_reg} + (CAP_W+1)'(size_reg);
    assign fits = (need <= {1'b0, capacity_reg}) && free_ok;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (start) state_next = ST_LOOKUP;
            ST_LOOKUP: if (ptr_reg == LAST_PTR) state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (found_reg || size_reg >= SIZE_W'(capacity_reg) &&
                    capacity_reg[CAP_W-1:SIZE_W] == '0 || use_reg == NEVER_USE)
                    state_next = ST_DONE;
                else if (fits)
                    state_next = ST_DONE;
                else
                    state_next = ST_SCAN;
            end
            ST_SCAN:   if (ptr_reg == LAST_PTR) state_next = ST_EVICT;
            ST_EVICT:  state_next = ST_DECIDE;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // memory write: hit update or insert
    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = free_idx;
        wr_data.key = key_reg;
        wr_data.size = size_reg;
        wr_data.next_use = use_reg;
        if (state_reg == ST_DECIDE && found_reg)
        begin
            wr_en = 1'b1;
            wr_addr = found_idx_reg;
            wr_data.size = best_size_reg;
        end
        else if (state_reg == ST_DECIDE && state_next == ST_DONE &&
                 !(size_reg >= SIZE_W'(capacity_reg) &&
                   capacity_reg[CAP_W-1:SIZE_W] == '0) &&
                 use_reg != NEVER_USE)
        begin
            wr_en = 1'b1;
        end
    end

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= '0;
        else if (cfg_we)
            capacity_reg <= cfg_wdata;
    end

    // control and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            occupied_reg <= '0;
            req_reg <= '0;
            miss_reg <= '0;
            ptr_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= 1'b0;
            unique case (state_reg) inside
                ST_IDLE:   ptr_reg <= '0;
                ST_LOOKUP, ST_SCAN:
                    ptr_reg <= (ptr_reg == LAST_PTR) ? '0 : ptr_reg + PTR_W'(1);
                ST_DECIDE:
                begin
                    ptr_reg <= '0;
                    if (!found_reg && wr_en)
                    begin
                        valid_reg[free_idx] <= 1'b1;
                        occupied_reg <= need[CAP_W-1:0];
                    end
                end
                ST_EVICT:
                begin
                    if (best_ok_reg)
                    begin
                        valid_reg[best_idx_reg] <= 1'b0;
                        occupied_reg <= (occupied_reg >= CAP_W'(best_size_reg)) ?
                            occupied_reg - CAP_W'(best_size_reg) : '0;
                    end
                end
                ST_DONE:
                begin
                    done_reg <= 1'b1;
                    if (req_reg != '1) req_reg <= req_reg + CNT_W'(1);
                    if (!hit_reg && miss_reg != '1) miss_reg <= miss_reg + CNT_W'(1);
                end
                default: ;
            endcase
        end
    end

    // per-request datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                key_reg <= item_key;
                size_reg <= item_size;
                use_reg <= next_use;
                found_reg <= 1'b0;
                hit_reg <= 1'b0;
                adm_reg <= 1'b0;
                evc_reg <= '0;
            end
            ST_LOOKUP:
            begin
                if (rd_live && !found_reg && rd_data.key == key_reg)
                begin
                    found_reg <= 1'b1;
                    hit_reg <= 1'b1;
                    found_idx_reg <= rd_idx;
                    best_size_reg <= rd_data.size;
                end
            end
            ST_DECIDE:
            begin
                best_ok_reg <= 1'b0;
                if (wr_en && !found_reg) adm_reg <= 1'b1;
            end
            ST_SCAN:
            begin
                if (rd_live && (!best_ok_reg || rd_data.next_use > best_use_reg))
                begin
                    best_ok_reg <= 1'b1;
                    best_idx_reg <= rd_idx;
                    best_use_reg <= rd_data.next_use;
                    best_size_reg <= rd_data.size;
                end
            end
            ST_EVICT:
            begin
                if (best_ok_reg)
                    evc_reg <= evc_reg + EVC_W'(1);
                else
                    use_reg <= NEVER_USE;
            end
            default: ;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign hit = hit_reg;
    assign admitted = adm_reg;
    assign evicted_count = evc_reg;
    assign occupied_size = occupied_reg;
    assign request_total = req_reg;
    assign miss_total = miss_reg;
endmodule

>>> rtl/orc_entry_mem.sv
`timescale 1ns / 1ps
module orc_entry_mem #(
    parameter int ENTRIES = 64,
    parameter int IDX_W = 6
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  orc_pkg::entry_t     wr_data,
    input  logic [IDX_W-1:0]    rd_addr,
    output orc_pkg::entry_t     rd_data
);
    import orc_pkg::*;

    entry_t mem [ENTRIES];

    // synchronous write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end
endmodule
